// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is asserted.
`define AM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that stays active during reset.
`define AM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/atmb_pkg.sv
// ----------------------------------------------------------------------------
// atmb_pkg
// Constants shared by the trimmed mean filter and its divider.
// ----------------------------------------------------------------------------
`default_nettype none

package atmb_pkg;

    localparam int unsigned SAMPLES_PER_BLOCK = 10;

    localparam int unsigned CODE_W = 10;
    localparam int unsigned GAIN_W = 26;
    localparam int unsigned MV_W   = 20;
    localparam int unsigned SUM_W  = 16;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned CNT_W  = $clog2(SAMPLES_PER_BLOCK);

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(37353213);
    localparam logic [CNT_W-1:0]  LAST_COUNT = CNT_W'(SAMPLES_PER_BLOCK - 1);
    localparam logic [CODE_W-1:0] CODE_MAX   = {CODE_W{1'b1}};

    localparam int unsigned DIVISOR  = SAMPLES_PER_BLOCK - 2;
    localparam int unsigned DIV_W    = $clog2(SAMPLES_PER_BLOCK - 1);
    localparam int unsigned RECIP_SH = SUM_W;
    localparam int unsigned RECIP    = (1 << RECIP_SH) / DIVISOR;
    localparam int unsigned RECIP_W  = RECIP_SH + 1;

endpackage

`default_nettype wire

// File: sv/atmb_div.sv
// ----------------------------------------------------------------------------
// atmb_div
// Divides the trimmed block sum by the sample count less two, using a
// reciprocal multiply and one correction step, pipelined over three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module atmb_div
    import atmb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [SUM_W-1:0]  i_trim,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [CODE_W-1:0]      o_mean
);

    localparam int unsigned PROD_W = SUM_W + RECIP_W;
    localparam int unsigned QD_W   = SUM_W + DIV_W;
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
    localparam logic [DIV_W-1:0]   DIV_V   = DIV_W'(DIVISOR);

    logic              r_t_valid;
    logic [SUM_W-1:0]  r_t_trim;
    logic              r_q_valid;
    logic [SUM_W-1:0]  r_q_trim;
    logic [SUM_W-1:0]  r_q_quot;
    logic              r_m_valid;
    logic [CODE_W-1:0] r_m_mean;

    logic              t_ready;
    logic              q_ready;
    logic              m_ready;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  n_q_quot;
    logic [QD_W-1:0]   qd;
    logic [QD_W-1:0]   rem;
    logic [SUM_W:0]    quot_fix;
    logic [CODE_W-1:0] n_m_mean;

    assign m_ready = !r_m_valid || i_ready;
    assign q_ready = !r_q_valid || m_ready;
    assign t_ready = !r_t_valid || q_ready;
    assign o_ready = t_ready;

    assign prod     = PROD_W'(r_t_trim) * PROD_W'(RECIP_V);
    assign n_q_quot = prod[RECIP_SH +: SUM_W];

    // The reciprocal estimate is low by at most one, so one compare fixes it.
    assign qd  = QD_W'(r_q_quot) * QD_W'(DIV_V);
    assign rem = QD_W'(r_q_trim) - qd;

    always_comb begin
        quot_fix = (SUM_W + 1)'(r_q_quot);
        if (rem >= QD_W'(DIV_V)) begin
            quot_fix = quot_fix + (SUM_W + 1)'(1);
        end
        if (quot_fix > (SUM_W + 1)'(CODE_MAX)) begin
            n_m_mean = CODE_MAX;
        end else begin
            n_m_mean = quot_fix[CODE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
            r_q_valid <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (t_ready) begin
                r_t_valid <= i_valid;
            end
            if (q_ready) begin
                r_q_valid <= r_t_valid;
            end
            if (m_ready) begin
                r_m_valid <= r_q_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (t_ready && i_valid) begin
            r_t_trim <= i_trim;
        end
        if (q_ready && r_t_valid) begin
            r_q_trim <= r_t_trim;
            r_q_quot <= n_q_quot;
        end
        if (m_ready && r_q_valid) begin
            r_m_mean <= n_m_mean;
        end
    end

    assign o_valid = r_m_valid;
    assign o_mean  = r_m_mean;

endmodule

`default_nettype wire

// File: sv/adc_trimmed_mean_block_unit.sv
// Pipeline: the last sample of a block is taken into the accumulate register;
// after it the stages are trim, reciprocal multiply, correction and gain
// multiply, each registered, and the last one drives the output.
// Throughput: one sample per cycle while the output is not stalled; blocks
// follow each other without a gap.
// Reset: synchronous, active low; clears the block and the pipeline and loads the default gain.
// ----------------------------------------------------------------------------
// adc_trimmed_mean_block_unit
// Groups ADC samples into blocks and gives the trimmed mean of each block
// together with the scaled input voltage in millivolts.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_trimmed_mean_block_unit
    import atmb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [GAIN_W-1:0] i_cfg_wdata,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [CODE_W-1:0] i_sample,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [CODE_W-1:0]      o_filtered_code,
    output logic [MV_W-1:0]        o_input_millivolts
);

    localparam int unsigned MUL_W = CODE_W + GAIN_W;

    logic [GAIN_W-1:0] r_gain;
    logic [SUM_W-1:0]  r_sum;
    logic [CODE_W-1:0] r_max;
    logic [CODE_W-1:0] r_min;
    logic [CNT_W-1:0]  r_count;
    logic              r_a_valid;
    logic [SUM_W-1:0]  r_a_sum;
    logic [CODE_W-1:0] r_a_max;
    logic [CODE_W-1:0] r_a_min;
    logic              r_o_valid;
    logic [CODE_W-1:0] r_o_code;
    logic [MV_W-1:0]   r_o_mv;

    logic              accept;
    logic              first;
    logic              last;
    logic [SUM_W-1:0]  n_sum;
    logic [CODE_W-1:0] n_max;
    logic [CODE_W-1:0] n_min;
    logic [SUM_W:0]    min_max;
    logic [SUM_W:0]    diff;
    logic [SUM_W-1:0]  trim;
    logic              div_ready;
    logic              div_valid;
    logic [CODE_W-1:0] div_mean;
    logic              out_ready;
    logic [MUL_W-1:0]  mv_full;

    assign o_stall = r_a_valid && !div_ready;
    assign accept  = i_valid && !o_stall;
    assign first   = (r_count == '0);
    assign last    = (r_count >= LAST_COUNT);

    always_comb begin
        if (first) begin
            n_sum = SUM_W'(i_sample);
            n_max = i_sample;
            n_min = i_sample;
        end else begin
            n_sum = r_sum + SUM_W'(i_sample);
            n_max = (i_sample > r_max) ? i_sample : r_max;
            n_min = (i_sample < r_min) ? i_sample : r_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= GAIN_RESET;
            r_sum     <= '0;
            r_count   <= '0;
            r_a_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gain <= i_cfg_wdata;
            end
            if (accept) begin
                if (last) begin
                    r_sum   <= '0;
                    r_count <= '0;
                end else begin
                    r_sum   <= n_sum;
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (accept && last) begin
                r_a_valid <= 1'b1;
            end else if (div_ready) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_max <= n_max;
            r_min <= n_min;
        end
        if (accept && last) begin
            r_a_sum <= n_sum;
            r_a_max <= n_max;
            r_a_min <= n_min;
        end
    end

    assign min_max = (SUM_W + 1)'(r_a_max) + (SUM_W + 1)'(r_a_min);
    assign diff    = (SUM_W + 1)'(r_a_sum) - min_max;
    assign trim    = ((SUM_W + 1)'(r_a_sum) < min_max) ? '0 : diff[SUM_W-1:0];

    atmb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_valid),
        .o_ready (div_ready),
        .i_trim  (trim),
        .o_valid (div_valid),
        .i_ready (out_ready),
        .o_mean  (div_mean)
    );

    assign out_ready = !r_o_valid || !i_stall;
    assign mv_full   = MUL_W'(div_mean) * MUL_W'(r_gain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_ready) begin
            r_o_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && div_valid) begin
            r_o_code <= div_mean;
            r_o_mv   <= mv_full[FRAC_W +: MV_W];
        end
    end

    assign o_valid            = r_o_valid;
    assign o_filtered_code    = r_o_code;
    assign o_input_millivolts = r_o_mv;

endmodule

`default_nettype wire

// File: sv/atmb_checker.sv
// ----------------------------------------------------------------------------
// atmb_checker
// Port-level checks for the trimmed mean filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module atmb_checker
    import atmb_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_stall,
    input wire logic              o_valid,
    input wire logic              i_stall,
    input wire logic [CODE_W-1:0] o_filtered_code,
    input wire logic [MV_W-1:0]   o_input_millivolts
);

    `AM_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_valid && !o_stall, "output not idle after reset")
    `AM_ASSERT(a_no_stall_when_empty, i_clk, i_rst_n, !o_valid |-> !o_stall, "input stalled with empty output")
    `AM_ASSERT(a_zero_code_zero_mv, i_clk, i_rst_n, o_valid && (o_filtered_code == '0) |-> (o_input_millivolts == '0), "nonzero voltage for zero code")
    `AM_ASSERT(a_out_valid_held, i_clk, i_rst_n, o_valid && i_stall |=> o_valid, "output item dropped while stalled")
    `AM_ASSERT(a_out_data_held, i_clk, i_rst_n, o_valid && i_stall |=> $stable(o_filtered_code) && $stable(o_input_millivolts), "output item changed while stalled")

endmodule

bind adc_trimmed_mean_block_unit atmb_checker u_atmb_checker (.*);

`default_nettype wire

// File: verif/adc_trimmed_mean_block_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adc_trimmed_mean_block_unit_tb
// Streams blocks of ADC samples into the trimmed mean filter, with random
// idling on both channels. A local model predicts the trimmed mean and the
// millivolt value of every completed block, and each result item is checked
// against it. The gain register is rewritten between phases, including its
// extremes.
// ----------------------------------------------------------------------------

module adc_trimmed_mean_block_unit_tb;
    import atmb_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [MV_W-1:0]   millivolts;
    } t_block_result;

    localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};
    localparam int SETTLE_CYCLES    = 12;
    localparam int RANDOM_PHASES    = 5;
    localparam int BLOCKS_PER_PHASE = 19;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [GAIN_W-1:0] i_cfg_wdata = '0;
    logic              i_valid = 1'b0;
    logic [CODE_W-1:0] i_sample = '0;
    logic              i_stall = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [CODE_W-1:0] o_filtered_code;
    logic [MV_W-1:0]   o_input_millivolts;

    logic [CODE_W-1:0] pending_samples[$];
    t_block_result     block_means[$];
    int                samples_in_flight = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                send_gap = 0;
    int                recv_gap = 0;
    int                mismatches = 0;

    logic [GAIN_W-1:0] gain_q = GAIN_RESET;
    logic [SUM_W-1:0]  sum_q = '0;
    logic [CODE_W-1:0] max_q = '0;
    logic [CODE_W-1:0] min_q = '0;
    int unsigned       count_q = 0;

    adc_trimmed_mean_block_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_sample           (i_sample),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_filtered_code    (o_filtered_code),
        .o_input_millivolts (o_input_millivolts)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic accumulate_sample(input logic [CODE_W-1:0] code);
        logic [SUM_W-1:0]         trimmed;
        logic [CODE_W-1:0]        mean;
        logic [CODE_W+GAIN_W-1:0] product;
        t_block_result            res;
        if (count_q == 0) begin
            max_q = code;
            min_q = code;
            sum_q = SUM_W'(code);
        end else begin
            if (code > max_q) max_q = code;
            if (code < min_q) min_q = code;
            sum_q = sum_q + SUM_W'(code);
        end
        if (count_q + 1 < SAMPLES_PER_BLOCK) begin
            count_q++;
        end else begin
            if (sum_q < SUM_W'(max_q) + SUM_W'(min_q)) trimmed = '0;
            else trimmed = sum_q - SUM_W'(max_q) - SUM_W'(min_q);
            if (trimmed / DIVISOR > CODE_MAX) mean = CODE_MAX;
            else mean = CODE_W'(trimmed / DIVISOR);
            product = mean * gain_q;
            res.code = mean;
            res.millivolts = product[FRAC_W +: MV_W];
            block_means.push_back(res);
            sum_q = '0;
            count_q = 0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                accumulate_sample(i_sample);
                samples_in_flight--;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    i_valid <= 1'b1;
                    i_sample <= pending_samples.pop_front();
                    if ($urandom_range(0, 99) < send_idle_pct) begin
                        send_gap <= $urandom_range(1, 17);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_block_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (block_means.size() == 0) begin
                    $display("%0t: result item expected none actual code %0d mv %0d", $time,
                             o_filtered_code, o_input_millivolts);
                    mismatches++;
                end else begin
                    want = block_means.pop_front();
                    if (o_filtered_code !== want.code) begin
                        $display("%0t: filtered_code expected %0d actual %0d", $time,
                                 want.code, o_filtered_code);
                        mismatches++;
                    end
                    if (o_input_millivolts !== want.millivolts) begin
                        $display("%0t: input_millivolts expected %0d actual %0d", $time,
                                 want.millivolts, o_input_millivolts);
                        mismatches++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                if ($urandom_range(0, 99) < recv_idle_pct) begin
                    recv_gap <= $urandom_range(1, 17);
                end
            end
        end
    end

    task automatic queue_sample(input logic [CODE_W-1:0] code);
        pending_samples.push_back(code);
        samples_in_flight++;
    endtask

    task automatic queue_random_block();
        int                pattern;
        logic [CODE_W-1:0] base;
        int                spread;
        pattern = $urandom_range(0, 9);
        base = CODE_W'($urandom);
        spread = $urandom_range(1, 15);
        for (int k = 0; k < SAMPLES_PER_BLOCK; k++) begin
            case (pattern)
                5: queue_sample(base);
                6: queue_sample($urandom_range(0, 1) ? CODE_MAX : '0);
                7: queue_sample(CODE_W'(base + $urandom_range(0, spread)));
                8: begin
                    case ($urandom_range(0, 2))
                        0: queue_sample(base);
                        1: queue_sample(CODE_MAX);
                        default: queue_sample('0);
                    endcase
                end
                9: queue_sample(CODE_W'($urandom_range(0, 3)));
                default: queue_sample(CODE_W'($urandom));
            endcase
        end
    endtask

    task automatic wait_until_idle();
        do @(negedge i_clk);
        while (samples_in_flight != 0 || block_means.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        gain_q = value;
        @(negedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 20;
        recv_idle_pct = 20;
        @(negedge i_clk);

        // Alternating extremes: ties on both the maximum and the minimum.
        for (int k = 0; k < SAMPLES_PER_BLOCK; k++) begin
            queue_sample(k[0] ? CODE_MAX : '0);
        end
        wait_until_idle();

        // Full-scale block at the largest gain gives the largest voltage.
        write_gain(GAIN_MAX);
        for (int k = 0; k < SAMPLES_PER_BLOCK; k++) begin
            queue_sample(CODE_MAX);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_until_idle();
            case (p)
                0: write_gain('0);
                1: write_gain(GAIN_W'($urandom));
                2: write_gain(GAIN_W'(1));
                3: write_gain(GAIN_W'($urandom));
                default: write_gain(GAIN_MAX);
            endcase
            if (p == RANDOM_PHASES - 1) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0: send_idle_pct = 0;
                    1: send_idle_pct = 8;
                    default: send_idle_pct = 30;
                endcase
                case ($urandom_range(0, 2))
                    0: recv_idle_pct = 0;
                    1: recv_idle_pct = 8;
                    default: recv_idle_pct = 30;
                endcase
            end
            for (int b = 0; b < BLOCKS_PER_PHASE; b++) begin
                queue_random_block();
            end
        end

        wait_until_idle();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
